### hdl/owsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owsm_pkg;

    localparam int ANGLE_W    = 10;
    localparam int SPEED_W    = 8;
    localparam int CORR_W     = 14;
    localparam int DRIVE_W    = 9;
    localparam int SCALE_W    = 12;
    localparam int SCALE_BITS = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_WHEELS = 4;
    localparam int NUM_SCALES = 2 * NUM_WHEELS;
    localparam int DRIVE_MAX  = 255;

    typedef logic        [ANGLE_W-1:0]   angle_t;
    typedef logic        [SPEED_W-1:0]   speed_t;
    typedef logic signed [CORR_W-1:0]    corr_t;
    typedef logic signed [DRIVE_W-1:0]   drive_t;
    typedef logic        [SCALE_W-1:0]   scale_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;

    // Wheel order is front left, front right, back right, back left.
    localparam int unsigned OFFSET_NUM [NUM_WHEELS] = '{43, 5, 19, 29};
    localparam int unsigned OFFSET_DEN = 48;

    // A set bit means the wheel subtracts the heading correction.
    localparam logic [NUM_WHEELS-1:0] CORR_SUB = 4'b1010;

    // Forward and reverse gain for each wheel in turn.
    localparam scale_t SCALE_RESET [NUM_SCALES] = '{
        12'd1075, 12'd1075, 12'd1280, 12'd1126,
        12'd973,  12'd922,  12'd973,  12'd973
    };

endpackage

`default_nettype wire

### hdl/owsm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface owsm_cmd_if;
    import owsm_pkg::*;

    logic   valid;
    logic   ready;
    angle_t heading_angle;
    speed_t base_speed;
    corr_t  turn_correction;

    modport source (output valid, heading_angle, base_speed, turn_correction, input ready);
    modport sink   (input valid, heading_angle, base_speed, turn_correction, output ready);
endinterface

interface owsm_drive_if;
    import owsm_pkg::*;

    logic   valid;
    logic   ready;
    drive_t fl_drive;
    drive_t fr_drive;
    drive_t br_drive;
    drive_t bl_drive;

    modport source (output valid, fl_drive, fr_drive, br_drive, bl_drive, input ready);
    modport sink   (input valid, fl_drive, fr_drive, br_drive, bl_drive, output ready);
endinterface

interface owsm_cfg_if;
    import owsm_pkg::*;

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    scale_t   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/omni_wheel_speed_mixer.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-wheel omni drive mixer. Each command beat (heading angle, base speed and signed
// heading correction) yields one beat of four saturated wheel drives. The datapath is a
// seven-stage pipeline: angle reduction, phase fold, cosine table read, speed multiply
// and correction, magnitude and gain selection, gain multiply, then saturation into the
// output register. A new command is taken every cycle unless the drive side stalls; each
// stage holds its beat only while the stage after it is full and stalled. The gain
// registers are written through the configuration channel, which is always ready, and
// should only be changed while no command is in flight.
module omni_wheel_speed_mixer #(
    parameter int ANGLE_STEPS   = 720,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    owsm_cfg_if.sink      cfg,
    owsm_cmd_if.sink      cmd,
    owsm_drive_if.source  drive
);
    import owsm_pkg::*;

    localparam int NSTG  = 7;
    localparam int AW    = $clog2(ANGLE_STEPS);
    localparam int EW    = ((AW > ANGLE_W) ? AW : ANGLE_W) + 1;
    localparam int PW    = AW + 1;
    localparam int TBL   = ANGLE_STEPS / 2 + 1;
    localparam int IW    = $clog2(TBL);
    localparam int COS_W = COS_FRAC_BITS + 2;
    localparam int RW    = COS_FRAC_BITS + 11;
    localparam int MW    = RW - 1;
    localparam int PRW   = MW + SCALE_W;

    localparam int unsigned WHEEL_OFFSET [NUM_WHEELS] = '{
        (OFFSET_NUM[0] * ANGLE_STEPS) / OFFSET_DEN,
        (OFFSET_NUM[1] * ANGLE_STEPS) / OFFSET_DEN,
        (OFFSET_NUM[2] * ANGLE_STEPS) / OFFSET_DEN,
        (OFFSET_NUM[3] * ANGLE_STEPS) / OFFSET_DEN
    };

    // Cosine table over the half turn, built at elaboration by the Taylor series in Q30.
    logic signed [COS_W-1:0] cos_tbl [TBL];

    for (genvar g = 0; g < TBL; g++) begin : g_cos
        localparam longint XR  = (longint'(g) * Q30_TWO_PI + longint'(ANGLE_STEPS / 2))
                                 / ANGLE_STEPS;
        localparam bit     NEG = (XR > Q30_HALF_PI);
        localparam longint XF  = NEG ? ((XR > Q30_PI) ? 64'sd0 : (Q30_PI - XR)) : XR;
        localparam longint X2  = (XF * XF) >> 30;
        localparam longint U6  = Q30_ONE - (((X2 * Q30_ONE) >> 30) / 132);
        localparam longint T6  = (U6 < 0) ? 64'sd0 : U6;
        localparam longint U5  = Q30_ONE - (((X2 * T6) >> 30) / 90);
        localparam longint T5  = (U5 < 0) ? 64'sd0 : U5;
        localparam longint U4  = Q30_ONE - (((X2 * T5) >> 30) / 56);
        localparam longint T4  = (U4 < 0) ? 64'sd0 : U4;
        localparam longint U3  = Q30_ONE - (((X2 * T4) >> 30) / 30);
        localparam longint T3  = (U3 < 0) ? 64'sd0 : U3;
        localparam longint U2  = Q30_ONE - (((X2 * T3) >> 30) / 12);
        localparam longint T2  = (U2 < 0) ? 64'sd0 : U2;
        localparam longint U1  = Q30_ONE - (((X2 * T2) >> 30) / 2);
        localparam longint T1  = (U1 < 0) ? 64'sd0 : U1;
        localparam longint C   = (T1 + (64'sd1 << (29 - COS_FRAC_BITS)))
                                 >> (30 - COS_FRAC_BITS);
        assign cos_tbl[g] = COS_W'(NEG ? -C : C);
    end

    scale_t scale_reg [NUM_SCALES];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SCALES; i++)
            begin
                scale_reg[i] <= SCALE_RESET[i];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SCALES; i++)
            begin
                if (cfg.valid && (cfg.index == CFG_IDX_W'(i)))
                begin
                    scale_reg[i] <= cfg.data;
                end
            end
        end
    end

    // Pipeline flow control: a stage loads when it is empty or the stage after it moves.
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] v_in;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || drive.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign v_in      = {v_reg[NSTG-2:0], cmd.valid};
    assign cmd.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (en & v_in) | (~en & v_reg);
        end
    end

    logic [AW-1:0]           ang_reg;
    logic [AW-1:0]           ang_next;
    speed_t                  spd1_reg;
    speed_t                  spd2_reg;
    speed_t                  spd3_reg;
    corr_t                   cor1_reg;
    corr_t                   cor2_reg;
    corr_t                   cor3_reg;
    logic [IW-1:0]           idx_reg  [NUM_WHEELS];
    logic [IW-1:0]           idx_next [NUM_WHEELS];
    logic signed [COS_W-1:0] cos_reg  [NUM_WHEELS];
    logic signed [RW-1:0]    raw_reg  [NUM_WHEELS];
    logic signed [RW-1:0]    raw_next [NUM_WHEELS];
    logic [MW-1:0]           mag_reg  [NUM_WHEELS];
    logic [MW-1:0]           mag_next [NUM_WHEELS];
    scale_t                  gain_reg [NUM_WHEELS];
    scale_t                  gain_next[NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   neg5_reg;
    logic [NUM_WHEELS-1:0]   neg6_reg;
    logic [PRW-1:0]          prod_reg [NUM_WHEELS];
    logic [PRW-1:0]          prod_next[NUM_WHEELS];
    drive_t                  drv_reg  [NUM_WHEELS];
    drive_t                  drv_next [NUM_WHEELS];

    // The angle input stays below three times the angle period, so two
    // conditional subtractions bring it into range.
    always_comb
    begin
        logic [EW-1:0] a0;
        logic [EW-1:0] a1;
        logic [EW-1:0] a2;
        a0 = EW'(cmd.heading_angle);
        a1 = (a0 >= EW'(ANGLE_STEPS)) ? (a0 - EW'(ANGLE_STEPS)) : a0;
        a2 = (a1 >= EW'(ANGLE_STEPS)) ? (a1 - EW'(ANGLE_STEPS)) : a1;
        ang_next = AW'(a2);
    end

    always_comb
    begin
        logic [PW-1:0] sum;
        logic [PW-1:0] ph;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            sum = PW'(ang_reg) + PW'(WHEEL_OFFSET[w]);
            ph  = (sum >= PW'(ANGLE_STEPS)) ? (sum - PW'(ANGLE_STEPS)) : sum;
            if ({ph, 1'b0} > (PW + 1)'(ANGLE_STEPS))
            begin
                idx_next[w] = IW'(PW'(ANGLE_STEPS) - ph);
            end
            else
            begin
                idx_next[w] = IW'(ph);
            end
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] spd_s;
        logic signed [RW-1:0] cos_s;
        logic signed [RW-1:0] cor_s;
        logic signed [RW-1:0] prd_s;
        spd_s = RW'($signed({1'b0, spd3_reg}));
        cor_s = RW'(cor3_reg) <<< (COS_FRAC_BITS - 4);
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            cos_s = RW'(cos_reg[w]);
            prd_s = cos_s * spd_s;
            raw_next[w] = CORR_SUB[w] ? (prd_s - cor_s) : (prd_s + cor_s);
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] r;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            r = raw_reg[w];
            mag_next[w]  = r[RW-1] ? MW'(-r) : MW'(r);
            gain_next[w] = r[RW-1] ? scale_reg[2 * w + 1] : scale_reg[2 * w];
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            prod_next[w] = PRW'(mag_reg[w]) * PRW'(gain_reg[w]);
        end
    end

    // The top gain-width bits of the product are the magnitude after the fraction shift.
    always_comb
    begin
        scale_t q;
        logic [DRIVE_W-1:0] sat;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            q   = prod_reg[w][PRW-1 -: SCALE_W];
            sat = (q > SCALE_W'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX) : DRIVE_W'(q);
            drv_next[w] = neg6_reg[w] ? drive_t'(-sat) : drive_t'(sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ang_reg  <= ang_next;
            spd1_reg <= cmd.base_speed;
            cor1_reg <= cmd.turn_correction;
        end
        if (en[1])
        begin
            idx_reg  <= idx_next;
            spd2_reg <= spd1_reg;
            cor2_reg <= cor1_reg;
        end
        if (en[2])
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                cos_reg[w] <= cos_tbl[idx_reg[w]];
            end
            spd3_reg <= spd2_reg;
            cor3_reg <= cor2_reg;
        end
        if (en[3])
        begin
            raw_reg <= raw_next;
        end
        if (en[4])
        begin
            mag_reg  <= mag_next;
            gain_reg <= gain_next;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                neg5_reg[w] <= raw_reg[w][RW-1];
            end
        end
        if (en[5])
        begin
            prod_reg <= prod_next;
            neg6_reg <= neg5_reg;
        end
        if (en[6])
        begin
            drv_reg <= drv_next;
        end
    end

    assign drive.valid    = v_reg[NSTG-1];
    assign drive.fl_drive = drv_reg[0];
    assign drive.fr_drive = drv_reg[1];
    assign drive.br_drive = drv_reg[2];
    assign drive.bl_drive = drv_reg[3];

endmodule

`default_nettype wire

### tb/owsm_drive_checker.sv
`timescale 1ns / 1ps

module owsm_drive_checker #(
    parameter int ANGLE_STEPS   = 720,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic  clk,
    input  logic  rst_n,
    owsm_cfg_if   cfg,
    owsm_cmd_if   cmd,
    owsm_drive_if drive,
    output int    errors,
    output int    pending
);
    import owsm_pkg::*;

    localparam int PRINT_CAP = 60;

    typedef drive_t [NUM_WHEELS-1:0] wheel_drives_t;

    scale_t        gain_reg [NUM_SCALES];
    wheel_drives_t drive_q [$];
    wheel_drives_t seen;
    wheel_drives_t wanted;
    string         wheel_tag [NUM_WHEELS] = '{"fl", "fr", "br", "bl"};
    int            i;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(string what);
        if (errors < PRINT_CAP)
            $display("%t mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint cosine_q(int unsigned phase);
        longint unsigned fold;
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned prod;
        longint unsigned rounded;
        longint          term;
        logic            negative;
        int              n;
        fold     = phase;
        negative = 1'b0;
        if (2 * fold > ANGLE_STEPS)
            fold = ANGLE_STEPS - fold;
        rad = (fold * Q30_TWO_PI + ANGLE_STEPS / 2) / ANGLE_STEPS;
        if (rad > Q30_HALF_PI)
        begin
            rad      = (rad > Q30_PI) ? 64'd0 : Q30_PI - rad;
            negative = 1'b1;
        end
        rad_sq = (rad * rad) >> 30;
        term   = Q30_ONE;
        for (n = 6; n >= 1; n--)
        begin
            prod = (rad_sq * longint'(term)) >> 30;
            term = Q30_ONE - longint'(prod / longint'((2 * n - 1) * (2 * n)));
            if (term < 0)
                term = 0;
        end
        rounded = (term + (64'sd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
        return negative ? -longint'(rounded) : longint'(rounded);
    endfunction

    function automatic drive_t wheel_drive(int w, int unsigned angle, longint speed,
                                           longint corr);
        int unsigned phase;
        longint      raw;
        longint      mag;
        scale_t      gain;
        phase = (angle + OFFSET_NUM[w] * ANGLE_STEPS / OFFSET_DEN) % ANGLE_STEPS;
        raw   = cosine_q(phase) * speed;
        if (CORR_SUB[w])
            raw = raw - corr * (64'sd1 << (COS_FRAC_BITS - 4));
        else
            raw = raw + corr * (64'sd1 << (COS_FRAC_BITS - 4));
        if (raw == 0)
            return '0;
        gain = (raw > 0) ? gain_reg[2 * w] : gain_reg[2 * w + 1];
        mag  = ((raw > 0) ? raw : -raw) * longint'(gain);
        mag  = mag >> (COS_FRAC_BITS + SCALE_BITS);
        if (mag > DRIVE_MAX)
            mag = DRIVE_MAX;
        return (raw > 0) ? drive_t'(mag) : drive_t'(-mag);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < NUM_SCALES; i++)
                gain_reg[i] = SCALE_RESET[i];
            drive_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                gain_reg[cfg.index] = cfg.data;
            if (drive.valid && drive.ready)
            begin
                seen = {drive.bl_drive, drive.br_drive, drive.fr_drive, drive.fl_drive};
                if (drive_q.size() == 0)
                    report_mismatch("drive beat arrived with no command outstanding");
                else
                begin
                    wanted = drive_q.pop_front();
                    for (i = 0; i < NUM_WHEELS; i++)
                        if (seen[i] !== wanted[i])
                            report_mismatch($sformatf("%s_drive is %0d, expected %0d",
                                                      wheel_tag[i], seen[i], wanted[i]));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                for (i = 0; i < NUM_WHEELS; i++)
                    wanted[i] = wheel_drive(i, cmd.heading_angle % ANGLE_STEPS,
                                            cmd.base_speed, cmd.turn_correction);
                drive_q.push_back(wanted);
            end
            pending = drive_q.size();
        end
    end

endmodule

### tb/tb_omni_wheel_speed_mixer.sv
`timescale 1ns / 1ps

module tb_omni_wheel_speed_mixer;
    import owsm_pkg::*;

    localparam int ANGLE_STEPS    = 720;
    localparam int COS_FRAC_BITS  = 15;
    localparam int PLAN_ITEMS     = 255;
    localparam int NUM_PLANS      = 6;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SCALE_TOP      = (1 << SCALE_W) - 1;
    localparam int SCALE_UNITY    = 1 << SCALE_BITS;
    localparam int SPEED_TOP      = (1 << SPEED_W) - 1;
    localparam int ANGLE_TOP      = (1 << ANGLE_W) - 1;
    localparam int CORR_TOP       = (1 << (CORR_W - 1)) - 1;
    localparam int CORR_BOTTOM    = -(1 << (CORR_W - 1));

    typedef enum int
    {
        PLAN_MAX,
        PLAN_ZERO,
        PLAN_RANDOM,
        PLAN_MIXED,
        PLAN_UNITY,
        PLAN_DEFAULT
    } gain_plan_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;
    bit   hold_req     = 1'b0;
    bit   tx_calm      = 1'b0;
    bit   rx_calm      = 1'b0;

    owsm_cfg_if   cfg_bus ();
    owsm_cmd_if   cmd_bus ();
    owsm_drive_if drive_bus ();

    omni_wheel_speed_mixer #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .drive (drive_bus)
    );

    owsm_drive_checker #(
        .ANGLE_STEPS   (ANGLE_STEPS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_drive_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .cmd     (cmd_bus),
        .drive   (drive_bus),
        .errors  (mismatches),
        .pending (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_cmd(int angle, int speed, int corr);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        gap = (tx_calm || hold_req) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.heading_angle   <= angle_t'(angle);
        cmd_bus.base_speed      <= speed_t'(speed);
        cmd_bus.turn_correction <= corr_t'(corr);
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task automatic write_scale(int index, int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= cfg_idx_t'(index);
        cfg_bus.data  <= scale_t'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin
        gain_plan_t plan;
        int         plan_no;
        int         item;
        int         idx;
        int         value;
        int         angle;
        int         speed;
        int         corr;
        rst_n                     <= 1'b0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= '0;
        cfg_bus.data              <= '0;
        cmd_bus.valid             <= 1'b0;
        cmd_bus.heading_angle     <= '0;
        cmd_bus.base_speed        <= '0;
        cmd_bus.turn_correction   <= '0;
        drive_bus.ready           <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(0, 0, 0);
        send_cmd(0, SPEED_TOP, 0);
        send_cmd(ANGLE_STEPS - 1, SPEED_TOP, 0);
        send_cmd(ANGLE_STEPS, SPEED_TOP, 0);
        send_cmd(ANGLE_TOP, SPEED_TOP, 0);
        send_cmd(512, 128, 0);
        send_cmd(90, 200, 0);
        send_cmd(180, 200, 0);
        send_cmd(360, 200, 0);
        send_cmd(540, 200, 0);
        send_cmd(255, SPEED_TOP, 0);
        send_cmd(105, SPEED_TOP, 0);
        send_cmd(0, 0, CORR_TOP);
        send_cmd(0, 0, CORR_BOTTOM);
        send_cmd(0, SPEED_TOP, CORR_TOP);
        send_cmd(0, SPEED_TOP, CORR_BOTTOM);
        send_cmd(360, SPEED_TOP, CORR_BOTTOM);
        send_cmd(0, 0, 1);
        send_cmd(0, 0, -1);
        send_cmd(120, 17, -300);
        send_cmd(0, 1, 0);

        for (plan_no = 0; plan_no < NUM_PLANS; plan_no++)
        begin
            plan = gain_plan_t'(plan_no);
            wait_drained();
            for (idx = 0; idx < NUM_SCALES; idx++)
            begin
                case (plan)
                    PLAN_MAX:    value = SCALE_TOP;
                    PLAN_ZERO:   value = 0;
                    PLAN_RANDOM: value = $urandom_range(0, SCALE_TOP);
                    PLAN_MIXED:
                    begin
                        case ($urandom_range(0, 3))
                            0:       value = 0;
                            1:       value = SCALE_TOP;
                            2:       value = SCALE_UNITY;
                            default: value = $urandom_range(0, SCALE_TOP);
                        endcase
                    end
                    PLAN_UNITY:  value = SCALE_UNITY;
                    default:     value = SCALE_RESET[idx];
                endcase
                write_scale(idx, value);
            end
            cfg_bus.valid <= 1'b0;

            for (item = 0; item < PLAN_ITEMS; item++)
            begin
                if (item == PLAN_ITEMS / 2)
                    hold_req = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    angle = $urandom_range(0, ANGLE_TOP);
                else
                    angle = $urandom_range(0, ANGLE_STEPS - 1);
                case ($urandom_range(0, 7))
                    0:       speed = 0;
                    1:       speed = SPEED_TOP;
                    default: speed = $urandom_range(0, SPEED_TOP);
                endcase
                case ($urandom_range(0, 7))
                    0:       corr = int'($urandom_range(0, (1 << CORR_W) - 1)) + CORR_BOTTOM;
                    1:       corr = ($urandom_range(0, 1) == 0) ? CORR_TOP : CORR_BOTTOM;
                    2:       corr = 0;
                    default: corr = int'($urandom_range(0, 1200)) - 600;
                endcase
                send_cmd(angle, speed, corr);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // A requested hold keeps ready low for a long stretch so that the pipeline fills
    // and back-pressures the command side.
    initial
    begin : drive_sink
        int stall;
        bit holding;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            stall   = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            holding = hold_req;
            if (holding)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                drive_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                if (holding)
                    hold_req = 1'b0;
            end
            drive_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!drive_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
            || (drive_bus.valid && drive_bus.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
